@@ src/ppp_pkg.sv @@
// Package for the perspective projection unit: register indexes, opcodes
// and the pipeline stage types. No dependencies.
package ppp_pkg;

	localparam int NUM_REGS = 7;
	localparam int IDX_W    = 3;
	localparam int QBITS    = 33;

	typedef enum logic [IDX_W-1:0] {
		REG_CLIP_X_SCALE     = 3'd0,
		REG_CLIP_Y_SCALE     = 3'd1,
		REG_CLIP_Z_SCALE     = 3'd2,
		REG_CLIP_Z_OFFSET    = 3'd3,
		REG_FRUSTUM_XY_SCALE = 3'd4,
		REG_FRUSTUM_Z_SCALE  = 3'd5,
		REG_FRUSTUM_Z_OFFSET = 3'd6
	} reg_idx_t;

	localparam logic OP_CLIP    = 1'b0;
	localparam logic OP_FRUSTUM = 1'b1;

	typedef struct packed {
		logic [63:0]      rem;
		logic [QBITS-1:0] quo;
		logic             neg;
		logic             ovf;
	} lane_t;

	typedef struct packed {
		lane_t [2:0] lane;
		logic [31:0] den;
		logic        dbz;
	} div_stage_t;

endpackage

@@ src/ppp_if.sv @@
// Valid/ready channel interfaces for the perspective projection unit.
// Depends on nothing.
interface ppp_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] x_in;
	logic [31:0] y_in;
	logic [31:0] z_in;
	logic [31:0] w_in;
	modport source (output valid, opcode, x_in, y_in, z_in, w_in, input ready);
	modport sink   (input valid, opcode, x_in, y_in, z_in, w_in, output ready);
endinterface

interface ppp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] x_out;
	logic [31:0] y_out;
	logic [31:0] z_out;
	logic        divide_by_zero;
	logic        saturated;
	modport source (output valid, x_out, y_out, z_out, divide_by_zero, saturated,
		input ready);
	modport sink   (input valid, x_out, y_out, z_out, divide_by_zero, saturated,
		output ready);
endinterface

@@ src/perspective_project_point_unit.sv @@
// Top level of the perspective projection unit: configuration registers,
// multiply stage, pipelined restoring divider and output register.
// Depends on ppp_pkg and the interfaces in ppp_if.sv.
//
// Usage: a point (opcode, x_in, y_in, z_in, w_in) is one transaction on in_pt;
// each point gives exactly one transaction on out_pt, in order. Coefficients
// are written through cfg_we / cfg_idx / cfg_wdata while the unit is idle.
// The pipeline is one multiply stage, one magnitude stage, one range check
// stage, 33 divider stages (one quotient bit each) and the output register,
// the first loaded at the accepting edge. One point is accepted every cycle
// while out_pt is not stalled. The whole pipeline advances together: when
// out_pt holds a result that is not taken, every stage holds and in_pt.ready
// is low; nothing is lost or repeated. Reset clears all valid bits and loads
// the coefficient reset values (scales 1.0, offsets 0). A zero depth gives
// zero outputs with divide_by_zero set; a quotient outside the signed 32-bit
// range is clamped and flagged.
module perspective_project_point_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	ppp_in_if.sink                 in_pt,
	ppp_out_if.source              out_pt,
	input  logic                   cfg_we,
	input  logic [ppp_pkg::IDX_W-1:0] cfg_idx,
	input  logic [31:0]            cfg_wdata
);
	import ppp_pkg::*;

	localparam logic [31:0] ONE = 32'(64'(1) << FRAC_BITS);

	logic [31:0] regs_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_CLIP_X_SCALE]     <= ONE;
			regs_q[REG_CLIP_Y_SCALE]     <= ONE;
			regs_q[REG_CLIP_Z_SCALE]     <= ONE;
			regs_q[REG_CLIP_Z_OFFSET]    <= '0;
			regs_q[REG_FRUSTUM_XY_SCALE] <= ONE;
			regs_q[REG_FRUSTUM_Z_SCALE]  <= ONE;
			regs_q[REG_FRUSTUM_Z_OFFSET] <= '0;
		end else if (cfg_we && (cfg_idx < IDX_W'(NUM_REGS))) begin
			regs_q[cfg_idx] <= cfg_wdata;
		end
	end

	logic en;
	logic out_valid_q;
	assign en = !out_valid_q || out_pt.ready;
	assign in_pt.ready = en;

	// Stage 1: products.
	logic [31:0] sx, sy, sz, oz;
	always_comb begin
		if (in_pt.opcode == OP_FRUSTUM) begin
			sx = regs_q[REG_FRUSTUM_XY_SCALE];
			sy = regs_q[REG_FRUSTUM_XY_SCALE];
			sz = regs_q[REG_FRUSTUM_Z_SCALE];
			oz = regs_q[REG_FRUSTUM_Z_OFFSET];
		end else begin
			sx = regs_q[REG_CLIP_X_SCALE];
			sy = regs_q[REG_CLIP_Y_SCALE];
			sz = regs_q[REG_CLIP_Z_SCALE];
			oz = regs_q[REG_CLIP_Z_OFFSET];
		end
	end

	logic signed [63:0] px_s1, py_s1, pz_s1, pw_s1;
	logic [31:0] z_s1;
	logic        v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_pt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= $signed(sx) * $signed(in_pt.x_in);
			py_s1 <= $signed(sy) * $signed(in_pt.y_in);
			pz_s1 <= $signed(sz) * $signed(in_pt.z_in);
			pw_s1 <= $signed(oz) * $signed(in_pt.w_in);
			z_s1  <= in_pt.z_in;
		end
	end

	// Stage 2: magnitudes and result signs.
	logic signed [64:0] sumz;
	logic [64:0]        sumz_mag;
	assign sumz     = 65'(pz_s1) + 65'(pw_s1);
	assign sumz_mag = sumz[64] ? (65'd0 - 65'(sumz)) : 65'(sumz);

	logic [63:0] mx_s2, my_s2, mz_s2;
	logic        nx_s2, ny_s2, nz_s2, dbz_s2, v_s2;
	logic [31:0] den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2  <= px_s1[63] ? (64'd0 - 64'(px_s1)) : 64'(px_s1);
			my_s2  <= py_s1[63] ? (64'd0 - 64'(py_s1)) : 64'(py_s1);
			mz_s2  <= sumz_mag[63:0];
			nx_s2  <= px_s1[63] ^ z_s1[31];
			ny_s2  <= py_s1[63] ^ z_s1[31];
			nz_s2  <= sumz[64] ^ z_s1[31];
			den_s2 <= z_s1[31] ? (32'd0 - z_s1) : z_s1;
			dbz_s2 <= (z_s1 == 32'd0);
		end
	end

	// Stage 3: quotient range check, then one quotient bit per stage.
	div_stage_t div_s3 [QBITS+1];
	logic       dv_s3  [QBITS+1];
	logic [63:0] mags [3];
	logic        negs [3];
	logic [65:0] lim;

	assign mags[0] = mx_s2;
	assign mags[1] = my_s2;
	assign mags[2] = mz_s2;
	assign negs[0] = nx_s2;
	assign negs[1] = ny_s2;
	assign negs[2] = nz_s2;
	assign lim = {den_s2, 34'd0} >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s3[0] <= 1'b0;
		end else if (en) begin
			dv_s3[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				div_s3[0].lane[l].rem <= mags[l];
				div_s3[0].lane[l].quo <= '0;
				div_s3[0].lane[l].neg <= negs[l];
				div_s3[0].lane[l].ovf <= ({2'b00, mags[l]} >= lim);
			end
			div_s3[0].den <= den_s2;
			div_s3[0].dbz <= dbz_s2;
		end
	end

	for (genvar k = 0; k < QBITS; k++) begin : g_div
		localparam int BIT = QBITS - 1 - k;
		logic [64:0] dsh;
		div_stage_t  div_nxt;
		assign dsh = 65'(div_s3[k].den) << BIT;

		always_comb begin
			div_nxt = div_s3[k];
			for (int l = 0; l < 3; l++) begin
				if ({1'b0, div_s3[k].lane[l].rem} >= dsh) begin
					div_nxt.lane[l].rem = div_s3[k].lane[l].rem - dsh[63:0];
					div_nxt.lane[l].quo[BIT] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s3[k+1] <= 1'b0;
			end else if (en) begin
				dv_s3[k+1] <= dv_s3[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s3[k+1] <= div_nxt;
			end
		end
	end

	// Output stage: sign, clamp and zero-depth override.
	logic [31:0] res [3];
	logic        lsat [3];
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (div_s3[QBITS].lane[l].neg) begin
				if (div_s3[QBITS].lane[l].ovf
				    || div_s3[QBITS].lane[l].quo > 33'h0_8000_0000) begin
					lsat[l] = 1'b1;
					res[l]  = 32'h8000_0000;
				end else begin
					lsat[l] = 1'b0;
					res[l]  = 32'd0 - div_s3[QBITS].lane[l].quo[31:0];
				end
			end else begin
				if (div_s3[QBITS].lane[l].ovf
				    || div_s3[QBITS].lane[l].quo > 33'h0_7FFF_FFFF) begin
					lsat[l] = 1'b1;
					res[l]  = 32'h7FFF_FFFF;
				end else begin
					lsat[l] = 1'b0;
					res[l]  = div_s3[QBITS].lane[l].quo[31:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_s3[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (div_s3[QBITS].dbz) begin
				out_pt.x_out          <= '0;
				out_pt.y_out          <= '0;
				out_pt.z_out          <= '0;
				out_pt.divide_by_zero <= 1'b1;
				out_pt.saturated      <= 1'b0;
			end else begin
				out_pt.x_out          <= res[0];
				out_pt.y_out          <= res[1];
				out_pt.z_out          <= res[2];
				out_pt.divide_by_zero <= 1'b0;
				out_pt.saturated      <= lsat[0] | lsat[1] | lsat[2];
			end
		end
	end

	assign out_pt.valid = out_valid_q;

	// A zero depth never reports saturation and always gives zero outputs.
	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_pt.valid && out_pt.divide_by_zero |->
			!out_pt.saturated && out_pt.x_out == 32'd0 && out_pt.y_out == 32'd0
			&& out_pt.z_out == 32'd0)
		else $error("zero depth result is not cleared");

	// A saturated result has at least one component at a rail.
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_pt.valid && out_pt.saturated |->
			out_pt.x_out == 32'h8000_0000 || out_pt.x_out == 32'h7FFF_FFFF
			|| out_pt.y_out == 32'h8000_0000 || out_pt.y_out == 32'h7FFF_FFFF
			|| out_pt.z_out == 32'h8000_0000 || out_pt.z_out == 32'h7FFF_FFFF)
		else $error("saturation flag without a clamped component");

	// A stalled output holds the whole pipeline, so the last stage keeps its item.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_pt.valid && !out_pt.ready |=> out_pt.valid && $stable(dv_s3[QBITS]))
		else $error("pipeline moved during an output stall");

endmodule

@@ bench/perspective_project_point_unit_tb.sv @@
// Testbench for perspective_project_point_unit: random and directed points under several
// coefficient settings and handshake idling patterns, checked against an inline predictor.
// Depends on ppp_pkg, ppp_if.sv and the unit itself.
`timescale 1ns / 100ps

module perspective_project_point_unit_tb;
	import ppp_pkg::*;

	localparam int PERIOD = 12;
	localparam int DRAIN_CYCLES = 45;
	localparam int STALL_LIMIT = 6000;
	localparam int MAX_REPORTS = 10;
	localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;
	localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] SMIN = 32'sh8000_0000;

	typedef struct {
		logic op;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
	} point_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic dbz;
		logic sat;
	} proj_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_idx;
	logic [31:0] cfg_wdata;

	ppp_in_if in_pt();
	ppp_out_if out_pt();

	perspective_project_point_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_pt(in_pt),
		.out_pt(out_pt),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	logic signed [31:0] coef [NUM_REGS];
	point_t pending_points[$];
	proj_t expected_projections[$];
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_sender;
	int mismatches;
	int points_sent;
	int projections_checked;
	int zero_depth_seen;
	int saturated_seen;
	int quiet_cycles;

	function automatic logic [31:0] divide_clamped(logic signed [31:0] a, logic signed [31:0] b,
		logic signed [31:0] c, logic signed [31:0] d, logic signed [31:0] den, inout logic sat);
		logic signed [65:0] ea, eb, ec, ed, eden, num;
		logic [65:0] mag, dmag, q;
		logic neg;
		ea = a;
		eb = b;
		ec = c;
		ed = d;
		eden = den;
		num = ea * eb + ec * ed;
		neg = num[65] ^ den[31];
		mag = num[65] ? 66'(-num) : 66'(num);
		dmag = den[31] ? 66'(-eden) : 66'(eden);
		q = mag / dmag;
		if (neg) begin
			if (q > 66'h8000_0000) begin
				sat = 1'b1;
				q = 66'h8000_0000;
			end
			return 32'(-q);
		end
		if (q > 66'h7fff_ffff) begin
			sat = 1'b1;
			q = 66'h7fff_ffff;
		end
		return q[31:0];
	endfunction

	function automatic proj_t project_point(point_t p);
		proj_t r;
		logic signed [31:0] sx, sy, sz, oz;
		logic sat;
		sat = 1'b0;
		if (p.op == OP_CLIP) begin
			sx = coef[REG_CLIP_X_SCALE];
			sy = coef[REG_CLIP_Y_SCALE];
			sz = coef[REG_CLIP_Z_SCALE];
			oz = coef[REG_CLIP_Z_OFFSET];
		end else begin
			sx = coef[REG_FRUSTUM_XY_SCALE];
			sy = coef[REG_FRUSTUM_XY_SCALE];
			sz = coef[REG_FRUSTUM_Z_SCALE];
			oz = coef[REG_FRUSTUM_Z_OFFSET];
		end
		if (p.z == 0) begin
			r = '{x: 0, y: 0, z: 0, dbz: 1'b1, sat: 1'b0};
			return r;
		end
		r.x = divide_clamped(sx, p.x, 0, 0, p.z, sat);
		r.y = divide_clamped(sy, p.y, 0, 0, p.z, sat);
		r.z = divide_clamped(sz, p.z, oz, p.w, p.z, sat);
		r.dbz = 1'b0;
		r.sat = sat;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #(PERIOD / 2) clk = ~clk;
	end

	// Driver: presents queued points and predicts each one as it is taken.
	always @(posedge clk or negedge arst_n) begin
		point_t p;
		if (!arst_n) begin
			in_pt.valid <= 1'b0;
			in_pt.opcode <= 1'b0;
			in_pt.x_in <= '0;
			in_pt.y_in <= '0;
			in_pt.z_in <= '0;
			in_pt.w_in <= '0;
		end else begin
			if (in_pt.valid && in_pt.ready) begin
				p = '{op: in_pt.opcode, x: in_pt.x_in, y: in_pt.y_in, z: in_pt.z_in,
					w: in_pt.w_in};
				expected_projections.push_back(project_point(p));
				points_sent++;
			end
			if (!in_pt.valid || in_pt.ready) begin
				if (pending_points.size() > 0 && !hold_sender &&
						$urandom_range(99) >= send_idle_pct) begin
					p = pending_points.pop_front();
					in_pt.valid <= 1'b1;
					in_pt.opcode <= p.op;
					in_pt.x_in <= p.x;
					in_pt.y_in <= p.y;
					in_pt.z_in <= p.z;
					in_pt.w_in <= p.w;
				end else begin
					in_pt.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every result transaction against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		proj_t e;
		if (!arst_n) begin
			out_pt.ready <= 1'b0;
		end else begin
			if (out_pt.valid && out_pt.ready) begin
				if (expected_projections.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("ERROR: unexpected result x=%h y=%h z=%h", out_pt.x_out,
							out_pt.y_out, out_pt.z_out);
				end else begin
					e = expected_projections.pop_front();
					projections_checked++;
					if (e.dbz)
						zero_depth_seen++;
					if (e.sat)
						saturated_seen++;
					if (out_pt.x_out !== e.x || out_pt.y_out !== e.y ||
							out_pt.z_out !== e.z || out_pt.divide_by_zero !== e.dbz ||
							out_pt.saturated !== e.sat) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("ERROR: result %0d expected x=%h y=%h z=%h dbz=%b sat=%b",
								projections_checked, e.x, e.y, e.z, e.dbz, e.sat);
							$display("       got x=%h y=%h z=%h dbz=%b sat=%b",
								out_pt.x_out, out_pt.y_out, out_pt.z_out,
								out_pt.divide_by_zero, out_pt.saturated);
						end
					end
				end
			end
			out_pt.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_pt.valid && in_pt.ready) || (out_pt.valid && out_pt.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic write_coef(logic [IDX_W-1:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		if (idx < NUM_REGS)
			coef[idx] = data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
		logic [31:0] v3, logic [31:0] v4, logic [31:0] v5, logic [31:0] v6);
		write_coef(REG_CLIP_X_SCALE, v0);
		write_coef(REG_CLIP_Y_SCALE, v1);
		write_coef(REG_CLIP_Z_SCALE, v2);
		write_coef(REG_CLIP_Z_OFFSET, v3);
		write_coef(REG_FRUSTUM_XY_SCALE, v4);
		write_coef(REG_FRUSTUM_Z_SCALE, v5);
		write_coef(REG_FRUSTUM_Z_OFFSET, v6);
	endtask

	task automatic queue_point(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic [31:0] w);
		point_t p;
		p = '{op: op, x: x, y: y, z: z, w: w};
		pending_points.push_back(p);
	endtask

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h0004_0000);
			2: return -$signed($urandom_range(32'h0004_0000));
			default: return ($urandom_range(1) != 0) ? SMAX : SMIN;
		endcase
	endfunction

	task automatic queue_random(int n);
		logic [31:0] x, y, z, w;
		repeat (n) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					x = $urandom;
					y = $urandom;
					z = $urandom;
					w = $urandom;
				end
				3: begin
					x = $urandom;
					y = $urandom;
					z = ($urandom_range(1) != 0) ? 32'd0 : (($urandom_range(1) != 0) ? 1 : -1);
					w = $urandom;
				end
				default: begin
					x = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
					y = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
					z = $urandom_range(32'h0100_0000, 32'h0000_1000);
					if ($urandom_range(3) == 0)
						z = -z;
					w = ($urandom_range(3) == 0) ? $urandom : ONE;
				end
			endcase
			queue_point(1'($urandom_range(1)), x, y, z, w);
		end
	endtask

	task automatic run_and_drain(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		while (pending_points.size() > 0 || in_pt.valid || expected_projections.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int phase;
		mismatches = 0;
		points_sent = 0;
		projections_checked = 0;
		zero_depth_seen = 0;
		saturated_seen = 0;
		quiet_cycles = 0;
		hold_sender = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		coef[REG_CLIP_X_SCALE] = ONE;
		coef[REG_CLIP_Y_SCALE] = ONE;
		coef[REG_CLIP_Z_SCALE] = ONE;
		coef[REG_CLIP_Z_OFFSET] = 0;
		coef[REG_FRUSTUM_XY_SCALE] = ONE;
		coef[REG_FRUSTUM_Z_SCALE] = ONE;
		coef[REG_FRUSTUM_Z_OFFSET] = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= '0;
		cfg_wdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed points with the reset coefficients.
		queue_point(OP_CLIP, ONE, ONE, ONE, ONE);
		queue_point(OP_FRUSTUM, ONE, -ONE, 2 * ONE, ONE);
		queue_point(OP_CLIP, 5, 7, 0, ONE);
		queue_point(OP_FRUSTUM, SMAX, SMIN, 0, SMAX);
		queue_point(OP_CLIP, SMAX, SMIN, 1, SMAX);
		queue_point(OP_FRUSTUM, SMAX, SMIN, -1, SMIN);
		queue_point(OP_CLIP, SMIN, SMAX, SMIN, SMIN);
		queue_point(OP_FRUSTUM, SMIN, SMIN, SMAX, SMAX);
		queue_point(OP_CLIP, -3, 3, -ONE, 0);
		queue_point(OP_CLIP, 32'h8000, 32'h7fff, ONE, ONE);
		run_and_drain(0, 0);

		write_all(SMAX, SMIN, SMAX, SMIN, SMIN, SMAX, SMAX);
		write_coef(REG_UNMAPPED, 32'h1234_5678);
		queue_point(OP_CLIP, SMAX, SMAX, 1, SMAX);
		queue_point(OP_CLIP, SMIN, SMIN, -1, SMIN);
		queue_point(OP_FRUSTUM, SMIN, SMAX, SMIN, SMIN);
		queue_point(OP_FRUSTUM, ONE, ONE, SMAX, SMIN);
		queue_point(OP_CLIP, 0, 0, ONE, 0);
		queue_point(OP_FRUSTUM, 0, 0, 0, 0);
		run_and_drain(0, 0);

		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: write_all(ONE, ONE, ONE, 0, ONE, ONE, 0);
				1: write_all(0, 0, 0, 0, 0, 0, 0);
				default: write_all(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
					rand_coef(), rand_coef(), rand_coef());
			endcase
			queue_random(120);
			if (phase == 5) begin
				hold_sender = 1'b1;
				send_idle_pct = 0;
				recv_stall_pct = 0;
				repeat (60) @(posedge clk);
				while (expected_projections.size() > 0)
					@(posedge clk);
				hold_sender = 1'b0;
			end
			case (phase % 4)
				0: run_and_drain(0, 0);
				1: run_and_drain(70, 0);
				2: run_and_drain(0, 70);
				default: run_and_drain(11, 11);
			endcase
		end

		$display("Summary: %0d points sent, %0d results checked, %0d zero-depth, %0d saturated",
			points_sent, projections_checked, zero_depth_seen, saturated_seen);
		$display("Covered clip and frustum modes over reset, extreme, zero and random coefficients.");
		if (mismatches == 0 && expected_projections.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				expected_projections.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/ppp_pkg.sv
src/ppp_if.sv
src/perspective_project_point_unit.sv
bench/perspective_project_point_unit_tb.sv
